### src/srdp_pkg.sv
// shared constants and types for the sparse row dot product engine
package srdp_pkg;

    localparam int VECTOR_DEPTH = 4096;
    localparam int VALUE_BITS   = 32;

    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int ADDR_W  = $clog2(VECTOR_DEPTH);
    localparam int PROD_W  = 2 * VALUE_BITS;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_MATRIX = 1'b1;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [VALUE_BITS-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

### src/srdp_req_if.sv
// request channel: vector loads and matrix nonzeros
interface srdp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [srdp_pkg::INDEX_W-1:0] index;
    logic signed [srdp_pkg::VALUE_W-1:0] value;
    logic                        entry_present;
    logic                        end_of_row;

    modport source (output valid, req_type, index, value, entry_present, end_of_row,
                    input ready);
    modport sink   (input valid, req_type, index, value, entry_present, end_of_row,
                    output ready);
endinterface

### src/srdp_res_if.sv
// result channel: row sums
interface srdp_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [srdp_pkg::SUM_W-1:0] row_sum;
    logic                              saturated;

    modport source (output valid, row_sum, saturated, input ready);
    modport sink   (input valid, row_sum, saturated, output ready);
endinterface

### src/srdp_vec_store.sv
// vector element memory, one write and one registered read per cycle
module srdp_vec_store (
    input  logic                                i_clk,
    input  srdp_pkg::t_wr_req                   i_wr,
    input  srdp_pkg::t_rd_req                   i_rd,
    output logic [srdp_pkg::VALUE_BITS-1:0]     o_rd_data
);

    logic [srdp_pkg::VALUE_BITS-1:0] r_mem [srdp_pkg::VECTOR_DEPTH];
    logic [srdp_pkg::VALUE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/sparse_row_dot_product.sv
// sparse row dot product: vector store read, multiply, saturating accumulate
// a row-end transfer in passes stage 1, stage 2 and the output register
// throughput: one item per cycle; the pipeline holds only while a row sum
//   waits for a full output register that is not being taken
// reset clears pipeline valids, accumulator, saturation flag and output valid;
//   the vector store is not cleared and needs no clearing pass
module sparse_row_dot_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srdp_req_if.sink    i_req,
    srdp_res_if.source  o_res
);

    logic                                   w_en;
    logic                                   w_acc_in;
    logic                                   w_in_range;
    srdp_pkg::t_wr_req                      w_wr;
    srdp_pkg::t_rd_req                      w_rd;
    logic [srdp_pkg::VALUE_BITS-1:0]        w_rd_data;

    logic                                   r1_valid;
    logic signed [srdp_pkg::VALUE_BITS-1:0] r1_coef;
    logic                                   r1_present;
    logic                                   r1_eor;
    logic                                   r1_in_range;
    logic signed [srdp_pkg::VALUE_BITS-1:0] w_elem;
    logic signed [srdp_pkg::PROD_W-1:0]     w_prod;

    logic                                   r2_valid;
    logic                                   r2_eor;
    logic signed [srdp_pkg::SUM_W-1:0]      r2_prod;

    logic signed [srdp_pkg::SUM_W-1:0]      r_acc;
    logic signed [srdp_pkg::SUM_W-1:0]      n_acc;
    logic                                   r_ovf;
    logic                                   n_ovf;
    logic signed [srdp_pkg::SUM_W-1:0]      w_sum;
    logic                                   w_pos_sat;
    logic                                   w_neg_sat;
    logic signed [srdp_pkg::SUM_W-1:0]      w_sat_sum;
    logic                                   w_emit;

    logic                                   r_out_valid;
    logic                                   n_out_valid;
    logic signed [srdp_pkg::SUM_W-1:0]      r_out_sum;
    logic                                   r_out_sat;

    // hold everything only when a row sum cannot move into the output register
    assign w_en     = !(r2_valid && r2_eor && r_out_valid && !o_res.ready);
    assign w_acc_in = i_req.valid && w_en;

    assign w_in_range = (32'(i_req.index) < 32'(srdp_pkg::VECTOR_DEPTH));

    assign w_wr.en   = w_acc_in && (i_req.req_type == srdp_pkg::REQ_LOAD) && w_in_range;
    assign w_wr.addr = srdp_pkg::ADDR_W'(i_req.index);
    assign w_wr.data = i_req.value[srdp_pkg::VALUE_BITS-1:0];
    assign w_rd.en   = w_en;
    assign w_rd.addr = srdp_pkg::ADDR_W'(i_req.index);

    srdp_vec_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // stage 1: memory read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_acc_in && (i_req.req_type == srdp_pkg::REQ_MATRIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_coef     <= i_req.value[srdp_pkg::VALUE_BITS-1:0];
            r1_present  <= i_req.entry_present;
            r1_eor      <= i_req.end_of_row;
            r1_in_range <= w_in_range;
        end
    end

    // stage 2: multiply
    assign w_elem = r1_in_range ? signed'(w_rd_data) : '0;
    assign w_prod = r1_coef * w_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_eor  <= r1_eor;
            r2_prod <= r1_present ? srdp_pkg::SUM_W'(w_prod) : '0;
        end
    end

    // stage 3: saturating accumulate
    assign w_sum     = r_acc + r2_prod;
    assign w_pos_sat = !r_acc[srdp_pkg::SUM_W-1] && !r2_prod[srdp_pkg::SUM_W-1]
                       && w_sum[srdp_pkg::SUM_W-1];
    assign w_neg_sat = r_acc[srdp_pkg::SUM_W-1] && r2_prod[srdp_pkg::SUM_W-1]
                       && !w_sum[srdp_pkg::SUM_W-1];
    assign w_emit    = w_en && r2_valid && r2_eor;

    always_comb begin
        priority if (w_pos_sat) begin
            w_sat_sum = {1'b0, {(srdp_pkg::SUM_W-1){1'b1}}};
        end else if (w_neg_sat) begin
            w_sat_sum = {1'b1, {(srdp_pkg::SUM_W-1){1'b0}}};
        end else begin
            w_sat_sum = w_sum;
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        if (w_en && r2_valid) begin
            if (r2_eor) begin
                n_acc = '0;
                n_ovf = 1'b0;
            end else begin
                n_acc = w_sat_sum;
                n_ovf = r_ovf || w_pos_sat || w_neg_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
        end
    end

    // output register
    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sum <= w_sat_sum;
            r_out_sat <= r_ovf || w_pos_sat || w_neg_sat;
        end
    end

    assign i_req.ready     = w_en;
    assign o_res.valid     = r_out_valid;
    assign o_res.row_sum   = r_out_sum;
    assign o_res.saturated = r_out_sat;

endmodule
